[src/vr_threshold_duty_from_rpm_unit_macros.svh]
// assertion macros shared by the vr threshold duty unit
`ifndef VR_THRESHOLD_DUTY_FROM_RPM_UNIT_MACROS_SVH
`define VR_THRESHOLD_DUTY_FROM_RPM_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/vtd_pkg.sv]
// shared types, constants and helpers of the vr threshold duty unit
package vtd_pkg;

    localparam int C_WORD_W     = 48;
    localparam int C_WORD_BYTES = 6;
    localparam int C_CHANNELS   = 2;
    localparam int C_ADDR_W     = 6;
    localparam int C_DATA_W     = 64;
    localparam int C_RPM_W      = 16;
    localparam int C_X_W        = 14;
    localparam int C_CV_W       = 8;
    localparam int C_SUPPLY_W   = 13;
    localparam int C_DUTY_W     = 14;
    localparam int C_ENABLE_W   = 2;
    localparam int C_PROD_W     = 26;
    localparam int C_IRW        = C_X_W + C_CV_W;
    localparam int C_DRW        = C_SUPPLY_W + C_DUTY_W;

    localparam logic [C_X_W-1:0]    C_RPM_BIN_UNIT      = 14'd50;
    localparam logic [C_CV_W-1:0]   C_ZERO_DRIVE_CV     = 8'd250;
    localparam logic [17:0]         C_DUTY_NUMER_PER_CV = 18'd132000;
    localparam logic [C_DUTY_W-1:0] C_DUTY_FULL         = 14'd10000;

    localparam logic [C_WORD_W-1:0]   C_RPM_POINTS_RST  = 48'h8C72_593F_260C;
    localparam logic [C_WORD_W-1:0]   C_VOLT_POINTS_RST = 48'h786C_6054_483C;
    localparam logic [C_ENABLE_W-1:0] C_ENABLE_RST      = 2'd0;
    localparam logic [C_SUPPLY_W-1:0] C_SUPPLY_RST      = 13'd3300;

    typedef enum logic [2:0] {
        REG_CURVE0_RPM,
        REG_CURVE0_VOLT,
        REG_CURVE1_RPM,
        REG_CURVE1_VOLT,
        REG_CHANNEL_ENABLE,
        REG_SUPPLY
    } t_reg_idx;

    typedef struct packed {
        logic              enable;
        logic              direct;
        logic [C_CV_W-1:0] cv_direct;
    } t_int_side;

    typedef struct packed {
        logic              enable;
        logic              zero;
        logic              sat;
        logic [C_CV_W-1:0] cv;
    } t_duty_side;

    function automatic logic [7:0] f_point(input logic [C_WORD_W-1:0] word, input int idx);
        logic [7:0] res;
        res = 8'd0;
        if (idx < C_WORD_BYTES) begin
            res = word[8*idx +: 8];
        end
        return res;
    endfunction

endpackage

[src/vtd_div.sv]
// pipelined restoring divider, one quotient bit per stage
module vtd_div #(
    parameter int DEN_W  = 14,
    parameter int QUO_W  = 8,
    parameter int SIDE_W = 10
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DEN_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]         i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [QUO_W-1:0]         o_quo,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int RW = DEN_W + QUO_W;

    logic [QUO_W-1:0]  r_vld;
    logic [RW-1:0]     r_rem  [QUO_W];
    logic [DEN_W-1:0]  r_den  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    logic [QUO_W-1:0]  w_adv;
    logic [QUO_W-1:0]  w_src_vld;
    logic [QUO_W-1:0]  w_take;
    logic [RW-1:0]     w_src_rem  [QUO_W];
    logic [DEN_W-1:0]  w_src_den  [QUO_W];
    logic [QUO_W-1:0]  w_src_quo  [QUO_W];
    logic [SIDE_W-1:0] w_src_side [QUO_W];
    logic [RW-1:0]     n_rem      [QUO_W];
    logic [QUO_W-1:0]  n_quo      [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [RW-1:0] w_shift;

        if (k == 0) begin : g_first
            assign w_src_vld[k]  = i_valid;
            assign w_src_rem[k]  = i_num;
            assign w_src_den[k]  = i_den;
            assign w_src_quo[k]  = '0;
            assign w_src_side[k] = i_side;
        end else begin : g_next
            assign w_src_vld[k]  = r_vld[k-1];
            assign w_src_rem[k]  = r_rem[k-1];
            assign w_src_den[k]  = r_den[k-1];
            assign w_src_quo[k]  = r_quo[k-1];
            assign w_src_side[k] = r_side[k-1];
        end

        assign w_shift   = RW'(w_src_den[k]) << (QUO_W - 1 - k);
        assign w_take[k] = w_src_rem[k] >= w_shift;
        assign n_rem[k]  = w_take[k] ? (w_src_rem[k] - w_shift) : w_src_rem[k];
        assign n_quo[k]  = w_take[k] ? (w_src_quo[k] | (QUO_W'(1) << (QUO_W - 1 - k)))
                                     : w_src_quo[k];
    end

    always_comb begin
        w_adv[QUO_W-1] = !r_vld[QUO_W-1] || i_ready;
        for (int k = QUO_W - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < QUO_W; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= w_src_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUO_W; k++) begin
            if (w_adv[k]) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_src_den[k];
                r_quo[k]  <= n_quo[k];
                r_side[k] <= w_src_side[k];
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

endmodule

[src/vtd_interp.sv]
// curve stages: bin scaling, segment choice, products and rounded dividend
module vtd_interp import vtd_pkg::*; #(
    parameter int CURVE_POINTS = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [C_RPM_W-1:0]  i_rpm,
    input  logic [C_WORD_W-1:0] i_rpm_word,
    input  logic [C_WORD_W-1:0] i_volt_word,
    input  logic                i_enable,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [C_IRW-1:0]    o_num,
    output logic [C_X_W-1:0]    o_den,
    output t_int_side           o_side
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    // stage a: bins in rpm
    logic [C_RPM_W-1:0]  r_a_rpm;
    logic [C_X_W-1:0]    r_a_x [CURVE_POINTS];
    logic [C_X_W-1:0]    n_a_x [CURVE_POINTS];
    logic [C_WORD_W-1:0] r_a_volt;
    logic                r_a_en;

    // stage b: segment
    logic                w_lo;
    logic                w_hi;
    logic                n_b_direct, r_b_direct;
    logic [C_CV_W-1:0]   n_b_cv, r_b_cv;
    logic [C_X_W-1:0]    n_b_x0, r_b_x0;
    logic [C_X_W-1:0]    n_b_x1, r_b_x1;
    logic [C_CV_W-1:0]   n_b_v0, r_b_v0;
    logic [C_CV_W-1:0]   n_b_v1, r_b_v1;
    logic [C_RPM_W-1:0]  r_b_rpm;
    logic                r_b_en;

    // stage c: weighted products
    logic [C_X_W-1:0]    w_dist_hi;
    logic [C_X_W-1:0]    w_dist_lo;
    logic [C_IRW-1:0]    n_c_p0, r_c_p0;
    logic [C_IRW-1:0]    n_c_p1, r_c_p1;
    logic [C_X_W-1:0]    n_c_d, r_c_d;
    logic                r_c_direct;
    logic [C_CV_W-1:0]   r_c_cv;
    logic                r_c_en;

    // stage d: dividend with half-up rounding
    logic [C_IRW-1:0]    n_d_num, r_d_num;
    logic [C_X_W-1:0]    n_d_den, r_d_den;
    t_int_side           n_d_side, r_d_side;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CURVE_POINTS; i++) begin
            n_a_x[i] = C_X_W'(f_point(i_rpm_word, i)) * C_RPM_BIN_UNIT;
        end
    end

    always_comb begin
        w_lo   = r_a_rpm <= C_RPM_W'(r_a_x[0]);
        w_hi   = r_a_rpm >= C_RPM_W'(r_a_x[CURVE_POINTS-1]);
        n_b_x0 = r_a_x[0];
        n_b_x1 = r_a_x[1];
        n_b_v0 = f_point(r_a_volt, 0);
        n_b_v1 = f_point(r_a_volt, 1);
        // highest start point at or below the speed
        for (int i = 1; i <= CURVE_POINTS - 2; i++) begin
            if (C_RPM_W'(r_a_x[i]) <= r_a_rpm) begin
                n_b_x0 = r_a_x[i];
                n_b_x1 = r_a_x[i+1];
                n_b_v0 = f_point(r_a_volt, i);
                n_b_v1 = f_point(r_a_volt, i + 1);
            end
        end
        n_b_direct = 1'b1;
        if (w_lo) begin
            n_b_cv = f_point(r_a_volt, 0);
        end else if (w_hi) begin
            n_b_cv = f_point(r_a_volt, CURVE_POINTS - 1);
        end else if (n_b_x1 <= n_b_x0) begin
            n_b_cv = n_b_v0;
        end else if (r_a_rpm >= C_RPM_W'(n_b_x1)) begin
            n_b_cv = n_b_v1;
        end else begin
            n_b_cv     = '0;
            n_b_direct = 1'b0;
        end
    end

    always_comb begin
        w_dist_hi = C_X_W'(C_RPM_W'(r_b_x1) - r_b_rpm);
        w_dist_lo = C_X_W'(r_b_rpm - C_RPM_W'(r_b_x0));
        n_c_p0    = C_IRW'(r_b_v0) * C_IRW'(w_dist_hi);
        n_c_p1    = C_IRW'(r_b_v1) * C_IRW'(w_dist_lo);
        n_c_d     = r_b_x1 - r_b_x0;
    end

    always_comb begin
        if (r_c_direct) begin
            n_d_num = '0;
            n_d_den = C_X_W'(1);
        end else begin
            n_d_num = r_c_p0 + r_c_p1 + C_IRW'(r_c_d >> 1);
            n_d_den = r_c_d;
        end
        n_d_side.enable    = r_c_en;
        n_d_side.direct    = r_c_direct;
        n_d_side.cv_direct = r_c_cv;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_rpm  <= i_rpm;
            r_a_x    <= n_a_x;
            r_a_volt <= i_volt_word;
            r_a_en   <= i_enable;
        end
        if (w_adv[1]) begin
            r_b_direct <= n_b_direct;
            r_b_cv     <= n_b_cv;
            r_b_x0     <= n_b_x0;
            r_b_x1     <= n_b_x1;
            r_b_v0     <= n_b_v0;
            r_b_v1     <= n_b_v1;
            r_b_rpm    <= r_a_rpm;
            r_b_en     <= r_a_en;
        end
        if (w_adv[2]) begin
            r_c_p0     <= n_c_p0;
            r_c_p1     <= n_c_p1;
            r_c_d      <= n_c_d;
            r_c_direct <= r_b_direct;
            r_c_cv     <= r_b_cv;
            r_c_en     <= r_b_en;
        end
        if (w_adv[3]) begin
            r_d_num  <= n_d_num;
            r_d_den  <= n_d_den;
            r_d_side <= n_d_side;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_num   = r_d_num;
    assign o_den   = r_d_den;
    assign o_side  = r_d_side;

endmodule

[src/vtd_duty.sv]
// duty stages: drive numerator, supply rounding and saturation test
module vtd_duty import vtd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [C_CV_W-1:0]     i_quo,
    input  t_int_side             i_side,
    input  logic [C_SUPPLY_W-1:0] i_supply,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [C_DRW-1:0]      o_num,
    output logic [C_SUPPLY_W-1:0] o_den,
    output t_duty_side            o_side
);

    localparam int STAGES = 2;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    logic [C_CV_W-1:0]     w_cv;
    logic                  w_zero;
    logic [C_CV_W-1:0]     w_diff;
    logic [C_PROD_W-1:0]   n_f_prod, r_f_prod;
    logic [C_SUPPLY_W-1:0] n_f_s, r_f_s;
    logic [C_CV_W-1:0]     r_f_cv;
    logic                  r_f_zero;
    logic                  r_f_en;

    logic [C_PROD_W-1:0]   w_np;
    logic                  w_sat;
    logic [C_DRW-1:0]      n_g_num, r_g_num;
    logic [C_SUPPLY_W-1:0] r_g_den;
    t_duty_side            n_g_side, r_g_side;

    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        w_cv     = i_side.direct ? i_side.cv_direct : i_quo;
        w_zero   = w_cv >= C_ZERO_DRIVE_CV;
        w_diff   = w_zero ? '0 : (C_ZERO_DRIVE_CV - w_cv);
        n_f_prod = C_PROD_W'(C_DUTY_NUMER_PER_CV) * C_PROD_W'(w_diff);
        // zero supply behaves as one millivolt
        n_f_s    = (i_supply == '0) ? C_SUPPLY_W'(1) : i_supply;
    end

    always_comb begin
        w_np            = r_f_prod + C_PROD_W'(r_f_s >> 1);
        w_sat           = C_DRW'(w_np) >= {r_f_s, C_DUTY_W'(0)};
        n_g_num         = w_sat ? '0 : C_DRW'(w_np);
        n_g_side.enable = r_f_en;
        n_g_side.zero   = r_f_zero;
        n_g_side.sat    = w_sat;
        n_g_side.cv     = r_f_cv;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_f_prod <= n_f_prod;
            r_f_s    <= n_f_s;
            r_f_cv   <= w_cv;
            r_f_zero <= w_zero;
            r_f_en   <= i_side.enable;
        end
        if (w_adv[1]) begin
            r_g_num  <= n_g_num;
            r_g_den  <= r_f_s;
            r_g_side <= n_g_side;
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[STAGES-1];
    assign o_num   = r_g_num;
    assign o_den   = r_g_den;
    assign o_side  = r_g_side;

endmodule

[src/vr_threshold_duty_from_rpm_unit.sv]
// top level of the vr threshold duty unit with its register port
// requests pass the curve stages, the curve divider, the duty stages, the duty divider and the result register
// throughput: one request per cycle while the output is not stalled, stalls collapse bubbles stage by stage
// most of the depth comes from the two bit-per-stage dividers (8 and 14 quotient bits)
// synchronous reset clears all valid flags and loads the register defaults
`include "vr_threshold_duty_from_rpm_unit_macros.svh"

module vr_threshold_duty_from_rpm_unit import vtd_pkg::*; #(
    parameter int CURVE_POINTS = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [C_RPM_W-1:0]    i_engine_rpm,
    input  logic                  i_channel,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [C_DUTY_W-1:0]   o_duty,
    output logic [C_CV_W-1:0]     o_threshold_centivolts,
    output logic                  o_updated,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [C_ADDR_W-1:0]   paddr,
    input  logic [C_DATA_W-1:0]   pwdata,
    output logic [C_DATA_W-1:0]   prdata,
    output logic                  pready
);

    logic [C_WORD_W-1:0]   r_curve0_rpm;
    logic [C_WORD_W-1:0]   r_curve0_volt;
    logic [C_WORD_W-1:0]   r_curve1_rpm;
    logic [C_WORD_W-1:0]   r_curve1_volt;
    logic [C_ENABLE_W-1:0] r_chan_en;
    logic [C_SUPPLY_W-1:0] r_supply;

    logic                  w_wr;
    t_reg_idx              w_idx;

    logic [C_WORD_W-1:0]   w_rpm_word;
    logic [C_WORD_W-1:0]   w_volt_word;
    logic                  w_enable;

    logic                  w_int_ready;
    logic                  w_int_valid;
    logic [C_IRW-1:0]      w_int_num;
    logic [C_X_W-1:0]      w_int_den;
    t_int_side             w_int_side;

    logic                  w_idiv_ready;
    logic                  w_idiv_valid;
    logic [C_CV_W-1:0]     w_idiv_quo;
    t_int_side             w_idiv_side;

    logic                  w_duty_ready;
    logic                  w_duty_valid;
    logic [C_DRW-1:0]      w_duty_num;
    logic [C_SUPPLY_W-1:0] w_duty_den;
    t_duty_side            w_duty_side;

    logic                  w_ddiv_ready;
    logic                  w_ddiv_valid;
    logic [C_DUTY_W-1:0]   w_ddiv_quo;
    t_duty_side            w_ddiv_side;

    logic                  w_out_adv;
    logic                  r_out_vld;
    logic [C_DUTY_W-1:0]   n_duty, r_duty;
    logic [C_CV_W-1:0]     n_cv, r_cv;
    logic                  r_upd;

    // register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[C_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve0_rpm  <= C_RPM_POINTS_RST;
            r_curve0_volt <= C_VOLT_POINTS_RST;
            r_curve1_rpm  <= C_RPM_POINTS_RST;
            r_curve1_volt <= C_VOLT_POINTS_RST;
            r_chan_en     <= C_ENABLE_RST;
            r_supply      <= C_SUPPLY_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CURVE0_RPM:     r_curve0_rpm  <= pwdata[C_WORD_W-1:0];
                REG_CURVE0_VOLT:    r_curve0_volt <= pwdata[C_WORD_W-1:0];
                REG_CURVE1_RPM:     r_curve1_rpm  <= pwdata[C_WORD_W-1:0];
                REG_CURVE1_VOLT:    r_curve1_volt <= pwdata[C_WORD_W-1:0];
                REG_CHANNEL_ENABLE: r_chan_en     <= pwdata[C_ENABLE_W-1:0];
                REG_SUPPLY:         r_supply      <= pwdata[C_SUPPLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CURVE0_RPM:     prdata = C_DATA_W'(r_curve0_rpm);
            REG_CURVE0_VOLT:    prdata = C_DATA_W'(r_curve0_volt);
            REG_CURVE1_RPM:     prdata = C_DATA_W'(r_curve1_rpm);
            REG_CURVE1_VOLT:    prdata = C_DATA_W'(r_curve1_volt);
            REG_CHANNEL_ENABLE: prdata = C_DATA_W'(r_chan_en);
            REG_SUPPLY:         prdata = C_DATA_W'(r_supply);
            default:            prdata = '0;
        endcase
    end

    // channel select
    assign w_rpm_word  = i_channel ? r_curve1_rpm  : r_curve0_rpm;
    assign w_volt_word = i_channel ? r_curve1_volt : r_curve0_volt;
    assign w_enable    = (int'(i_channel) < C_CHANNELS) && r_chan_en[i_channel];
    assign o_in_stall  = !w_int_ready;

    vtd_interp #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_interp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (w_int_ready),
        .i_rpm       (i_engine_rpm),
        .i_rpm_word  (w_rpm_word),
        .i_volt_word (w_volt_word),
        .i_enable    (w_enable),
        .o_valid     (w_int_valid),
        .i_ready     (w_idiv_ready),
        .o_num       (w_int_num),
        .o_den       (w_int_den),
        .o_side      (w_int_side)
    );

    vtd_div #(
        .DEN_W  (C_X_W),
        .QUO_W  (C_CV_W),
        .SIDE_W ($bits(t_int_side))
    ) u_idiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_int_valid),
        .o_ready (w_idiv_ready),
        .i_num   (w_int_num),
        .i_den   (w_int_den),
        .i_side  (w_int_side),
        .o_valid (w_idiv_valid),
        .i_ready (w_duty_ready),
        .o_quo   (w_idiv_quo),
        .o_side  (w_idiv_side)
    );

    vtd_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_idiv_valid),
        .o_ready  (w_duty_ready),
        .i_quo    (w_idiv_quo),
        .i_side   (w_idiv_side),
        .i_supply (r_supply),
        .o_valid  (w_duty_valid),
        .i_ready  (w_ddiv_ready),
        .o_num    (w_duty_num),
        .o_den    (w_duty_den),
        .o_side   (w_duty_side)
    );

    vtd_div #(
        .DEN_W  (C_SUPPLY_W),
        .QUO_W  (C_DUTY_W),
        .SIDE_W ($bits(t_duty_side))
    ) u_ddiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_duty_valid),
        .o_ready (w_ddiv_ready),
        .i_num   (w_duty_num),
        .i_den   (w_duty_den),
        .i_side  (w_duty_side),
        .o_valid (w_ddiv_valid),
        .i_ready (w_out_adv),
        .o_quo   (w_ddiv_quo),
        .o_side  (w_ddiv_side)
    );

    // result register
    assign w_out_adv = !r_out_vld || !i_out_stall;

    always_comb begin
        if (!w_ddiv_side.enable || w_ddiv_side.zero) begin
            n_duty = '0;
        end else if (w_ddiv_side.sat || (w_ddiv_quo > C_DUTY_FULL)) begin
            n_duty = C_DUTY_FULL;
        end else begin
            n_duty = w_ddiv_quo;
        end
        n_cv = w_ddiv_side.enable ? w_ddiv_side.cv : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_adv) begin
            r_out_vld <= w_ddiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_duty <= n_duty;
            r_cv   <= n_cv;
            r_upd  <= w_ddiv_side.enable;
        end
    end

    assign o_out_valid            = r_out_vld;
    assign o_duty                 = r_duty;
    assign o_threshold_centivolts = r_cv;
    assign o_updated              = r_upd;

    `VTD_ASSERT_NOW(a_skip_zero, o_out_valid && !o_updated, (o_duty == '0) && (o_threshold_centivolts == '0), "skipped channel gives a nonzero result")
    `VTD_ASSERT_NOW(a_duty_range, o_out_valid, o_duty <= C_DUTY_FULL, "duty above full scale")
    `VTD_ASSERT_NOW(a_zero_drive, o_out_valid && o_updated && (o_threshold_centivolts >= C_ZERO_DRIVE_CV), o_duty == '0, "threshold at zero drive gives nonzero duty")
    `VTD_ASSERT_NOW(a_empty_ready, !o_out_valid, !o_in_stall, "request stalled while result register empty")
    `VTD_ASSERT_NEXT(a_supply_write, w_wr && (w_idx == REG_SUPPLY), r_supply == $past(pwdata[C_SUPPLY_W-1:0]), "supply register write lost")

endmodule

[tb/vtd_duty_checker.sv]
// checker for the vr threshold duty unit: tracks register writes, predicts each result, compares
`timescale 1ns / 100ps

module vtd_duty_checker import vtd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [C_RPM_W-1:0]  i_engine_rpm,
    input  logic                i_channel,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [C_DUTY_W-1:0] i_duty,
    input  logic [C_CV_W-1:0]   i_threshold_centivolts,
    input  logic                i_updated,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [C_ADDR_W-1:0] i_paddr,
    input  logic [C_DATA_W-1:0] i_pwdata,
    input  logic                i_pready,
    output int                  o_pending,
    output int                  o_fail_count
);

    localparam int POINTS     = 6;
    localparam int BIN_RPM    = 50;
    localparam int ZERO_CV    = 250;
    localparam int DUTY_PER_CV = 132000;
    localparam int DUTY_MAX   = 10000;

    typedef struct packed {
        logic [C_DUTY_W-1:0] duty;
        logic [C_CV_W-1:0]   cv;
        logic                updated;
    } t_duty_result;

    logic [C_WORD_W-1:0]   curve0_rpm_cfg;
    logic [C_WORD_W-1:0]   curve0_volt_cfg;
    logic [C_WORD_W-1:0]   curve1_rpm_cfg;
    logic [C_WORD_W-1:0]   curve1_volt_cfg;
    logic [C_ENABLE_W-1:0] enable_cfg;
    logic [C_SUPPLY_W-1:0] supply_cfg;

    t_duty_result expected_duty_q [$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic t_duty_result predict_duty(input logic [C_RPM_W-1:0] rpm,
                                                  input logic ch);
        t_duty_result        res;
        logic [C_WORD_W-1:0] rpms;
        logic [C_WORD_W-1:0] volts;
        int                  x [POINTS];
        int                  v [POINTS];
        int                  r;
        int                  seg;
        int                  d;
        int                  cv;
        int                  k;
        longint              sup;
        longint              n;
        res = '0;
        if (!enable_cfg[ch]) begin
            return res;
        end
        rpms  = ch ? curve1_rpm_cfg : curve0_rpm_cfg;
        volts = ch ? curve1_volt_cfg : curve0_volt_cfg;
        for (k = 0; k < POINTS; k++) begin
            x[k] = BIN_RPM * int'(rpms[8*k +: 8]);
            v[k] = int'(volts[8*k +: 8]);
        end
        r = int'(rpm);
        if (r <= x[0]) begin
            cv = v[0];
        end else if (r >= x[POINTS-1]) begin
            cv = v[POINTS-1];
        end else begin
            seg = 0;
            for (k = 0; k < POINTS - 1; k++) begin
                if (x[k] <= r) begin
                    seg = k;
                end
            end
            if (x[seg+1] <= x[seg]) begin
                cv = v[seg];
            end else if (r >= x[seg+1]) begin
                cv = v[seg+1];
            end else begin
                d  = x[seg+1] - x[seg];
                cv = (v[seg] * (x[seg+1] - r) + v[seg+1] * (r - x[seg]) + d / 2) / d;
            end
        end
        if (cv < ZERO_CV) begin
            sup = (supply_cfg == '0) ? 64'sd1 : longint'(supply_cfg);
            n = longint'(DUTY_PER_CV) * longint'(ZERO_CV - cv);
            n = (n + sup / 2) / sup;
            if (n > DUTY_MAX) begin
                n = DUTY_MAX;
            end
            res.duty = n[C_DUTY_W-1:0];
        end
        res.cv      = cv[C_CV_W-1:0];
        res.updated = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_duty_result want;
        if (!i_rst_n) begin
            curve0_rpm_cfg  <= C_RPM_POINTS_RST;
            curve0_volt_cfg <= C_VOLT_POINTS_RST;
            curve1_rpm_cfg  <= C_RPM_POINTS_RST;
            curve1_volt_cfg <= C_VOLT_POINTS_RST;
            enable_cfg      <= C_ENABLE_RST;
            supply_cfg      <= C_SUPPLY_RST;
            expected_duty_q.delete();
            o_pending       <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[5:3]))
                    REG_CURVE0_RPM:     curve0_rpm_cfg  <= i_pwdata[C_WORD_W-1:0];
                    REG_CURVE0_VOLT:    curve0_volt_cfg <= i_pwdata[C_WORD_W-1:0];
                    REG_CURVE1_RPM:     curve1_rpm_cfg  <= i_pwdata[C_WORD_W-1:0];
                    REG_CURVE1_VOLT:    curve1_volt_cfg <= i_pwdata[C_WORD_W-1:0];
                    REG_CHANNEL_ENABLE: enable_cfg      <= i_pwdata[C_ENABLE_W-1:0];
                    REG_SUPPLY:         supply_cfg      <= i_pwdata[C_SUPPLY_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_duty_q.size() == 0) begin
                    report_mismatch("result with no request pending", int'(i_duty), 0);
                end else begin
                    want = expected_duty_q.pop_front();
                    if (i_duty !== want.duty) begin
                        report_mismatch("duty", int'(i_duty), int'(want.duty));
                    end
                    if (i_threshold_centivolts !== want.cv) begin
                        report_mismatch("threshold_centivolts", int'(i_threshold_centivolts),
                                        int'(want.cv));
                    end
                    if (i_updated !== want.updated) begin
                        report_mismatch("updated", int'(i_updated), int'(want.updated));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_duty_q.push_back(predict_duty(i_engine_rpm, i_channel));
            end
            o_pending <= expected_duty_q.size();
        end
    end

endmodule

[tb/vr_threshold_duty_from_rpm_unit_test.sv]
// testbench top for the vr threshold duty unit: register setup, request stimulus and verdict
`timescale 1ns / 100ps

module vr_threshold_duty_from_rpm_unit_test;
    import vtd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [C_RPM_W-1:0]    i_engine_rpm = '0;
    logic                  i_channel = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [C_DUTY_W-1:0]   o_duty;
    logic [C_CV_W-1:0]     o_threshold_centivolts;
    logic                  o_updated;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [C_ADDR_W-1:0]   paddr = '0;
    logic [C_DATA_W-1:0]   pwdata = '0;
    logic [C_DATA_W-1:0]   prdata;
    logic                  pready;

    int                    pending_count;
    int                    fail_count;
    int                    quiet_cycles = 0;
    int                    idle_pct = 0;
    logic                  stall_on = 1'b0;
    int                    stall_left = 0;
    logic [C_WORD_W-1:0]   rpm_word [C_CHANNELS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vr_threshold_duty_from_rpm_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_engine_rpm           (i_engine_rpm),
        .i_channel              (i_channel),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_duty                 (o_duty),
        .o_threshold_centivolts (o_threshold_centivolts),
        .o_updated              (o_updated),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    vtd_duty_checker duty_checker (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .i_in_stall             (o_in_stall),
        .i_engine_rpm           (i_engine_rpm),
        .i_channel              (i_channel),
        .i_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .i_duty                 (o_duty),
        .i_threshold_centivolts (o_threshold_centivolts),
        .i_updated              (o_updated),
        .i_psel                 (psel),
        .i_penable              (penable),
        .i_pwrite               (pwrite),
        .i_paddr                (paddr),
        .i_pwdata               (pwdata),
        .i_pready               (pready),
        .o_pending              (pending_count),
        .o_fail_count           (fail_count)
    );

    always @(posedge i_clk) begin
        if (!stall_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left  <= int'($urandom_range(0, 12));
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [C_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_request(input logic [C_RPM_W-1:0] rpm, input logic ch);
        int gap;
        if (idle_pct > 0 && int'($urandom_range(0, 99)) < idle_pct) begin
            gap = int'($urandom_range(1, 13));
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_engine_rpm <= rpm;
        i_channel    <= ch;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold off requests until every outstanding result has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [C_WORD_W-1:0] gen_rpm_curve();
        logic [C_WORD_W-1:0] w;
        logic [31:0]         a;
        logic [31:0]         c;
        int                  b;
        int                  k;
        int                  sel;
        sel = int'($urandom_range(0, 19));
        a = $urandom();
        c = $urandom();
        if (sel == 0) begin
            w = '0;
        end else if (sel == 1) begin
            w = '1;
        end else if (sel <= 4) begin
            w = {a[15:0], c};
        end else begin
            b = int'($urandom_range(0, 40));
            for (k = 0; k < C_WORD_BYTES; k++) begin
                w[8*k +: 8] = b[7:0];
                b = b + (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 40)));
            end
        end
        return w;
    endfunction

    function automatic logic [C_WORD_W-1:0] gen_volt_curve();
        logic [31:0] a;
        logic [31:0] c;
        int          sel;
        sel = int'($urandom_range(0, 9));
        a = $urandom();
        c = $urandom();
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return '1;
        end
        return {a[15:0], c};
    endfunction

    // half the time near the curve bins, otherwise anywhere in the rpm range, at its ends or up to 13000
    function automatic logic [C_RPM_W-1:0] pick_rpm(input logic [C_WORD_W-1:0] rpms);
        int r;
        int k;
        case ($urandom_range(0, 9))
            0: r = int'($urandom_range(0, 65535));
            1: r = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            2, 3, 4: r = int'($urandom_range(0, 13000));
            default: begin
                k = int'($urandom_range(0, C_WORD_BYTES - 1));
                r = 50 * int'(rpms[8*k +: 8]) + int'($urandom_range(0, 120)) - 60;
                if (r < 0) begin
                    r = 0;
                end
            end
        endcase
        return r[C_RPM_W-1:0];
    endfunction

    task automatic run_directed();
        // channels disabled after reset
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b1);
        send_request(16'd1000, 1'b0);
        wait_drain();
        write_reg(REG_CHANNEL_ENABLE, 64'd3);
        // default curves: below, on and past the end bins, plus the top rpm bit
        send_request(16'd0, 1'b0);
        send_request(16'd600, 1'b0);
        send_request(16'd601, 1'b0);
        send_request(16'd1900, 1'b0);
        send_request(16'd2345, 1'b1);
        send_request(16'd6999, 1'b1);
        send_request(16'd7000, 1'b0);
        send_request(16'd7001, 1'b1);
        send_request(16'hFFFF, 1'b0);
        send_request(16'd12345, 1'b1);
        send_request(16'h8000, 1'b1);
        wait_drain();
        // unordered curve with equal bins, zero supply, channel 1 off
        rpm_word[0] = 48'h3C32_1414_1E0A;
        write_reg(REG_CURVE0_RPM, 64'hA5A5_3C32_1414_1E0A);
        write_reg(REG_CURVE0_VOLT, 64'h5A5A_FA32_FFC8_6400);
        write_reg(REG_SUPPLY, 64'd0);
        write_reg(REG_CHANNEL_ENABLE, 64'd1);
        send_request(16'd400, 1'b0);
        send_request(16'd500, 1'b0);
        send_request(16'd999, 1'b0);
        send_request(16'd1000, 1'b0);
        send_request(16'd1200, 1'b0);
        send_request(16'd2500, 1'b0);
        send_request(16'd2999, 1'b0);
        send_request(16'd3000, 1'b0);
        send_request(16'd3100, 1'b1);
    endtask

    task automatic run_random_phase(input int idx, input int n_items, input logic calm);
        logic [31:0]           a;
        logic [C_WORD_W-1:0]   volt_word;
        logic [C_ENABLE_W-1:0] en;
        int                    sup;
        int                    k;
        logic                  ch;
        wait_drain();
        for (k = 0; k < C_CHANNELS; k++) begin
            a = $urandom();
            rpm_word[k] = gen_rpm_curve();
            volt_word = gen_volt_curve();
            write_reg((k == 0) ? REG_CURVE0_RPM : REG_CURVE1_RPM, {a[15:0], rpm_word[k]});
            write_reg((k == 0) ? REG_CURVE0_VOLT : REG_CURVE1_VOLT, {a[31:16], volt_word});
        end
        case (idx)
            0: sup = 3300;
            1: sup = 1000;
            2: sup = 5000;
            3: sup = 0;
            4: sup = 8191;
            default: sup = int'($urandom_range(1000, 5000));
        endcase
        a = $urandom();
        write_reg(REG_SUPPLY, {32'd0, a[31:13], sup[12:0]});
        en = calm ? 2'd3 : (($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : 2'd3);
        a = $urandom();
        write_reg(REG_CHANNEL_ENABLE, {32'd0, a[31:2], en});
        stall_on = !calm;
        idle_pct = (calm || idx % 3 == 0) ? 0 : int'($urandom_range(5, 40));
        for (k = 0; k < n_items; k++) begin
            ch = 1'($urandom_range(0, 1));
            send_request(pick_rpm(rpm_word[ch]), ch);
        end
    endtask

    initial begin
        int p;
        rpm_word[0] = C_RPM_POINTS_RST;
        rpm_word[1] = C_RPM_POINTS_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stall_on = 1'b1;
        idle_pct = 25;
        run_directed();
        for (p = 0; p < 8; p++) begin
            run_random_phase(p, 85, p == 7);
        end
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/vtd_pkg.sv
src/vtd_div.sv
src/vtd_interp.sv
src/vtd_duty.sv
src/vr_threshold_duty_from_rpm_unit.sv
tb/vtd_duty_checker.sv
tb/vr_threshold_duty_from_rpm_unit_test.sv
